// ===== hw/rtl/ibfd_pkg.sv =====
// Package: shared constants, types and helpers for the IMU burst decoder.
`default_nettype none
package ibfd_pkg;
    localparam int BurstLen = 24;
    localparam int CountW   = 5;

    localparam logic [2:0] CfgGyroRange = 3'd0;
    localparam logic [2:0] CfgAccelRange = 3'd1;
    localparam logic [2:0] CfgMagAdjust = 3'd2;
    localparam logic [2:0] CfgAccelOffset = 3'd3;
    localparam logic [2:0] CfgHardIron = 3'd4;
    localparam logic [2:0] CfgSoftIron = 3'd5;

    // Captured burst words handed from front to back.
    typedef struct packed {
        logic [2:0][15:0] acc;
        logic [2:0][15:0] gyr;
        logic [2:0][15:0] mag;
        logic             motion;
        logic             field;
    } burst_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_FIX,
        ST_GAIN,
        ST_ROUND,
        ST_OUT
    } calc_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/imu_burst_frame_decode_top.sv =====
// Top level: IMU burst decoder with config registers and queue handshakes.
// Takes one burst byte per accepted push. Byte 23 starts the back end: motion
// terms are latched on that edge, and a field update runs each magnetometer
// axis through multiply, scale, shift-add divide by 4095, remainder fix-up,
// soft-iron gain and rounding. push is blocked while the back end works, and
// stays blocked while a finished result waits behind an earlier one that has
// not been popped; a single waiting result does not block.
`default_nettype none
module imu_burst_frame_decode_top
    import ibfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  burst_byte,
    input  wire logic        frame_start,
    output logic             empty,
    input  wire logic        pop,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic signed [31:0] rate_x,
    output logic signed [31:0] rate_y,
    output logic signed [31:0] rate_z,
    output logic signed [31:0] field_x,
    output logic signed [31:0] field_y,
    output logic signed [31:0] field_z,
    output logic             motion_valid,
    output logic             field_valid,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    logic [1:0]  gyro_range_reg, accel_range_reg;
    logic [23:0] mag_adjust_reg;
    logic [47:0] accel_offset_reg, hard_iron_reg, soft_iron_reg;
    logic        take, done, busy, res_valid;
    burst_t      burst;
    logic [31:0] res_data [9];

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_range_reg <= '0;
            accel_range_reg <= '0;
            mag_adjust_reg <= 24'h808080;
            accel_offset_reg <= '0;
            hard_iron_reg <= '0;
            soft_iron_reg <= 48'h400040004000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgGyroRange:   gyro_range_reg <= cfg_data[1:0];
                CfgAccelRange:  accel_range_reg <= cfg_data[1:0];
                CfgMagAdjust:   mag_adjust_reg <= cfg_data[23:0];
                CfgAccelOffset: accel_offset_reg <= cfg_data;
                CfgHardIron:    hard_iron_reg <= cfg_data;
                CfgSoftIron:    soft_iron_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign full = busy;
    assign take = push && !full;
    assign empty = !res_valid;

    ibfd_front u_front (
        .clk, .rst_n, .take, .burst_byte, .frame_start, .done, .burst
    );

    ibfd_back u_back (
        .clk, .rst_n, .start(done), .burst,
        .gyro_range(gyro_range_reg), .accel_range(accel_range_reg),
        .mag_adjust(mag_adjust_reg), .accel_offset(accel_offset_reg),
        .hard_iron_offset(hard_iron_reg), .soft_iron_gain(soft_iron_reg),
        .busy, .res_valid, .res_take(pop), .res_data,
        .res_motion(motion_valid), .res_field(field_valid)
    );

    assign accel_x = res_data[0];
    assign accel_y = res_data[1];
    assign accel_z = res_data[2];
    assign rate_x  = res_data[3];
    assign rate_y  = res_data[4];
    assign rate_z  = res_data[5];
    assign field_x = res_data[6];
    assign field_y = res_data[7];
    assign field_z = res_data[8];
endmodule
`default_nettype wire

// ===== hw/rtl/ibfd_front.sv =====
// Front end: byte counter, burst capture and classification.
`default_nettype none
module ibfd_front
    import ibfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] burst_byte,
    input  wire logic       frame_start,
    output logic            done,
    output burst_t          burst
);
    logic [CountW-1:0] count_reg, count_next;
    logic [7:0]        store_reg [BurstLen];
    logic [CountW-1:0] pos;

    // position of the incoming byte
    always_comb
    begin
        pos = frame_start ? '0 : count_reg;
        if (pos >= CountW'(BurstLen))
            pos = '0;
        count_next = (pos == CountW'(BurstLen - 1)) ? '0 : pos + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (take)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            store_reg[pos] <= burst_byte;
    end

    assign done = take && (pos == CountW'(BurstLen - 1));

    // assemble words; byte 23 comes straight from the input
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            burst.acc[i] = {store_reg[1 + 2 * i], store_reg[2 + 2 * i]};
            burst.gyr[i] = {store_reg[9 + 2 * i], store_reg[10 + 2 * i]};
        end
        burst.mag[0] = {store_reg[18], store_reg[17]};
        burst.mag[1] = {store_reg[20], store_reg[19]};
        burst.mag[2] = {store_reg[22], store_reg[21]};
        burst.motion = store_reg[0][0];
        burst.field  = store_reg[16][0] && !burst_byte[3];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ibfd_back.sv =====
// Back end: scaling, calibration and saturation of one captured burst.
`default_nettype none
module ibfd_back
    import ibfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire burst_t      burst,
    input  wire logic [1:0]  gyro_range,
    input  wire logic [1:0]  accel_range,
    input  wire logic [23:0] mag_adjust,
    input  wire logic [47:0] accel_offset,
    input  wire logic [47:0] hard_iron_offset,
    input  wire logic [47:0] soft_iron_gain,
    output logic             busy,
    output logic             res_valid,
    input  wire logic        res_take,
    output logic [31:0]      res_data [9],
    output logic             res_motion,
    output logic             res_field
);
    calc_state_t state_reg, state_next;
    burst_t      b_reg;
    logic [1:0]  ax_reg, ax_next;
    logic signed [31:0] motion_reg [6];
    logic signed [31:0] field_reg [3];
    logic signed [24:0] sens_reg;      // raw*(adj+128)
    logic [40:0] m_reg;                // |raw*(adj+128)|*157184 + 2047
    logic        neg_reg;
    logic [29:0] q_reg;                // m/4095 estimate, low by at most 3
    logic signed [31:0] h_reg;         // rounded h
    logic signed [47:0] g_reg;         // d*gain
    logic        out_valid_reg;

    logic [7:0]  adj;
    logic [8:0]  adj9;
    logic signed [15:0] hoff;
    logic [15:0] gain;
    logic [23:0] sens_abs;
    logic [13:0] rem;
    logic [1:0]  corr;
    logic [29:0] q_fix;
    logic signed [31:0] dval;
    logic [47:0] g_abs;
    logic [33:0] g_rnd;

    always_comb
    begin
        adj  = mag_adjust[8 * ax_reg +: 8];
        adj9 = {1'b0, adj} + 9'd128;
        hoff = hard_iron_offset[16 * ax_reg +: 16];
        gain = soft_iron_gain[16 * ax_reg +: 16];
        sens_abs = sens_reg[24] ? 24'(-sens_reg) : 24'(sens_reg);
        // m - 4095*q, only the low 14 bits matter since it stays below 4*4095
        rem = m_reg[13:0] - {q_reg[1:0], 12'd0} + q_reg[13:0];
        corr = (rem >= 14'd12285) ? 2'd3 :
               (rem >= 14'd8190)  ? 2'd2 :
               (rem >= 14'd4095)  ? 2'd1 : 2'd0;
        q_fix = q_reg + 30'(corr);
        dval = h_reg - (32'(hoff) <<< 14);
        g_abs = g_reg[47] ? 48'(-g_reg) : 48'(g_reg);
        g_rnd = 34'((g_abs + 48'd8192) >> 14);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ax_next = ax_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = burst.field ? ST_MUL : ST_OUT;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_FIX;
            ST_FIX:   state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (ax_reg == 2'd2)
                begin
                    state_next = ST_OUT;
                    ax_next = '0;
                end
                else
                begin
                    state_next = ST_MUL;
                    ax_next = ax_reg + 1'b1;
                end
            end
            ST_OUT:   if (!out_valid_reg || res_take) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ax_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) motion_reg[i] <= '0;
            for (int i = 0; i < 3; i++) field_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg <= ax_next;
            if (state_reg == ST_OUT && (!out_valid_reg || res_take))
                out_valid_reg <= 1'b1;
            else if (res_take)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE && start && burst.motion)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    motion_reg[i] <= sat32(
                        (64'($signed(burst.acc[i])) <<< (2 + accel_range))
                        - (64'($signed(accel_offset[16 * i +: 16])) <<< 4));
                    motion_reg[3 + i] <= 32'($signed(burst.gyr[i])) * (
                        (gyro_range == 2'd0) ? 32'sd500 :
                        (gyro_range == 2'd1) ? 32'sd1000 :
                        (gyro_range == 2'd2) ? 32'sd2000 : 32'sd4000);
                end
            end
            if (state_reg == ST_ROUND)
                field_reg[ax_reg] <= sat32(g_reg[47] ? -$signed({30'd0, g_rnd})
                                                     : $signed({30'd0, g_rnd}));
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            b_reg <= burst;
        if (state_reg == ST_MUL)
            sens_reg <= 25'($signed(b_reg.mag[ax_reg])) * 25'($signed({1'b0, adj9}));
        if (state_reg == ST_SCALE)
        begin
            // rounding bias of half the divisor folded in here
            m_reg <= 41'(sens_abs) * 41'd157184 + 41'd2047;
            neg_reg <= sens_reg[24];
        end
        // 1/4095 as 1/4096 + 1/4096^2 + 1/4096^3, fixed up next cycle
        if (state_reg == ST_DIV)
            q_reg <= 30'(m_reg >> 12) + 30'(m_reg >> 24) + 30'(m_reg >> 36);
        if (state_reg == ST_FIX)
            h_reg <= neg_reg ? -$signed({2'b0, q_fix}) : $signed({2'b0, q_fix});
        if (state_reg == ST_GAIN)
            g_reg <= 48'(dval) * 48'($signed({1'b0, gain}));
        if (state_reg == ST_OUT && (!out_valid_reg || res_take))
        begin
            res_motion <= b_reg.motion;
            res_field <= b_reg.field;
            for (int i = 0; i < 6; i++) res_data[i] <= motion_reg[i];
            for (int i = 0; i < 3; i++) res_data[6 + i] <= field_reg[i];
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== bench/imu_burst_frame_decode_top_tb.sv =====
// Testbench for the IMU burst decoder: directed table, random bursts, predictor check.
`default_nettype none
module imu_burst_frame_decode_top_tb;
    import ibfd_pkg::*;

    // Expected result of one burst
    typedef struct {
        logic signed [31:0] acc [3];
        logic signed [31:0] rate [3];
        logic signed [31:0] fld [3];
        logic               motion;
        logic               field;
        logic               fixed;    // directed row with typed-in value
    } imu_sample_t;

    // Directed stimulus row
    typedef struct {
        logic [7:0] data;
        logic       start;
    } byte_req_t;

    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 400;
    localparam logic [2:0] CfgUnused = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  burst_byte;
    logic        frame_start;
    logic        empty;
    logic        pop;
    logic signed [31:0] accel_x, accel_y, accel_z;
    logic signed [31:0] rate_x, rate_y, rate_z;
    logic signed [31:0] field_x, field_y, field_z;
    logic        motion_valid;
    logic        field_valid;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    imu_burst_frame_decode_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .burst_byte(burst_byte), .frame_start(frame_start),
        .empty(empty), .pop(pop),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
        .field_x(field_x), .field_y(field_y), .field_z(field_z),
        .motion_valid(motion_valid), .field_valid(field_valid),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state and registers
    logic [1:0]  gyro_sel;
    logic [1:0]  accel_sel;
    logic [23:0] mag_sens;
    logic [47:0] accel_bias;
    logic [47:0] iron_offset;
    logic [47:0] iron_gain;
    int          byte_pos;
    logic [7:0]  burst_buf [BurstLen];
    logic signed [31:0] held_motion [6];
    logic signed [31:0] held_field [3];

    imu_sample_t expected_samples [$];
    int  errors;
    int  pending_fixed;
    imu_sample_t fixed_sample;
    bit  long_hold_req;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint s16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint round_div(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Apply a register write to the predictor
    task automatic model_cfg(input logic [2:0] idx, input logic [47:0] val);
        case (idx)
            CfgGyroRange:   gyro_sel = val[1:0];
            CfgAccelRange:  accel_sel = val[1:0];
            CfgMagAdjust:   mag_sens = val[23:0];
            CfgAccelOffset: accel_bias = val;
            CfgHardIron:    iron_offset = val;
            CfgSoftIron:    iron_gain = val;
            default: ;
        endcase
    endtask

    // Decode a finished burst into one expected sample
    task automatic decode_burst(output imu_sample_t s);
        longint full_scale;
        longint a, g, raw, adj, h, d, gain;
        logic   mot, fld;
        mot = burst_buf[0][0];
        fld = burst_buf[16][0] && !burst_buf[23][3];
        case (gyro_sel)
            2'd0: full_scale = 250;
            2'd1: full_scale = 500;
            2'd2: full_scale = 1000;
            default: full_scale = 2000;
        endcase
        if (mot)
        begin
            for (int i = 0; i < 3; i++)
            begin
                raw = s16({burst_buf[1 + 2 * i], burst_buf[2 + 2 * i]});
                a = raw * (longint'(4) << accel_sel) - s16(accel_bias[16 * i +: 16]) * 16;
                raw = s16({burst_buf[9 + 2 * i], burst_buf[10 + 2 * i]});
                g = raw * 2 * full_scale;
                held_motion[i] = clamp32(a);
                held_motion[3 + i] = clamp32(g);
            end
        end
        if (fld)
        begin
            for (int i = 0; i < 3; i++)
            begin
                adj = longint'(mag_sens[8 * i +: 8]);
                raw = s16({burst_buf[18 + 2 * i], burst_buf[17 + 2 * i]});
                h = round_div(raw * (adj + 128) * 157184, 4095);
                d = h - s16(iron_offset[16 * i +: 16]) * 16384;
                gain = longint'(iron_gain[16 * i +: 16]);
                held_field[i] = clamp32(round_div(d * gain, 16384));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            s.acc[i] = held_motion[i];
            s.rate[i] = held_motion[3 + i];
            s.fld[i] = held_field[i];
        end
        s.motion = mot;
        s.field = fld;
        s.fixed = 1'b0;
    endtask

    // Predictor step for one accepted byte
    task automatic model_byte(input logic [7:0] data, input logic start);
        imu_sample_t s;
        int p;
        bit differ;
        p = start ? 0 : byte_pos;
        if (p >= BurstLen)
            p = 0;
        burst_buf[p] = data;
        if (p == BurstLen - 1)
        begin
            byte_pos = 0;
            decode_burst(s);
            if (pending_fixed > 0)
            begin
                // typed-in value must agree with the predictor too
                s.fixed = 1'b1;
                pending_fixed--;
                differ = 1'b0;
                for (int i = 0; i < 3; i++)
                    if (s.acc[i] != fixed_sample.acc[i] || s.rate[i] != fixed_sample.rate[i]
                        || s.fld[i] != fixed_sample.fld[i])
                        differ = 1'b1;
                if (differ)
                begin
                    $display("%0t predictor disagrees with typed-in sample", $time);
                    errors++;
                end
                s = fixed_sample;
                s.fixed = 1'b1;
            end
            expected_samples.push_back(s);
        end
        else
            byte_pos = p + 1;
    endtask

    // Offer one byte and wait for acceptance
    task automatic send_byte(input logic [7:0] data, input logic start);
        push <= 1'b1;
        burst_byte <= data;
        frame_start <= start;
        @(posedge clk);
        while (full)
            @(posedge clk);
        model_byte(data, start);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
            push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_all();
        push <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_cfg(idx, val);
        @(posedge clk);
    endtask

    // Random burst: mostly well-formed, some noise and resyncs
    task automatic random_burst();
        logic [7:0] b;
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : BurstLen;
        for (int i = 0; i < len; i++)
        begin
            b = $urandom_range(0, 255);
            if (i == 0 && $urandom_range(0, 3) != 0)
                b[0] = 1'b1;
            if (i == 16 && $urandom_range(0, 3) != 0)
                b[0] = 1'b1;
            if (i == 23 && $urandom_range(0, 3) != 0)
                b[3] = 1'b0;
            // extreme samples now and then
            if (i >= 1 && i <= 22 && $urandom_range(0, 7) == 0)
                b = ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7f;
            send_byte(b, (i == 0) ? ($urandom_range(0, 1) != 0) : ($urandom_range(0, 40) == 0));
            idle_gap();
        end
    endtask

    task automatic random_cfg();
        write_cfg(CfgGyroRange, 48'($urandom_range(0, 3)));
        write_cfg(CfgAccelRange, 48'($urandom_range(0, 3)));
        write_cfg(CfgMagAdjust, 48'($urandom_range(0, 24'hffffff)));
        write_cfg(CfgAccelOffset, {$urandom(), $urandom()});
        write_cfg(CfgHardIron, {$urandom(), $urandom()});
        write_cfg(CfgSoftIron, {$urandom(), $urandom()});
        // unused index is ignored
        write_cfg(CfgUnused, {$urandom(), $urandom()});
    endtask

    // Result side: random pop gaps, long holds on request
    initial begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                pop <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
                pop <= 1'b0;
            else if ($urandom_range(0, 30) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(20, 200)) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        imu_sample_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t unexpected result accel_x=%0d", $time, accel_x);
                errors++;
            end
            else
            begin
                e = expected_samples.pop_front();
                if (accel_x !== e.acc[0] || accel_y !== e.acc[1] || accel_z !== e.acc[2])
                begin
                    $display("%0t accel exp %0d %0d %0d got %0d %0d %0d", $time,
                        e.acc[0], e.acc[1], e.acc[2], accel_x, accel_y, accel_z);
                    errors++;
                end
                if (rate_x !== e.rate[0] || rate_y !== e.rate[1] || rate_z !== e.rate[2])
                begin
                    $display("%0t rate exp %0d %0d %0d got %0d %0d %0d", $time,
                        e.rate[0], e.rate[1], e.rate[2], rate_x, rate_y, rate_z);
                    errors++;
                end
                if (field_x !== e.fld[0] || field_y !== e.fld[1] || field_z !== e.fld[2])
                begin
                    $display("%0t field exp %0d %0d %0d got %0d %0d %0d", $time,
                        e.fld[0], e.fld[1], e.fld[2], field_x, field_y, field_z);
                    errors++;
                end
                if (motion_valid !== e.motion || field_valid !== e.field)
                begin
                    $display("%0t valid flags exp %b%b got %b%b", $time,
                        e.motion, e.field, motion_valid, field_valid);
                    errors++;
                end
            end
        end
    end

    // Cycle limit
    initial begin
        @(posedge rst_n);
        repeat (CycleLimit) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // Stimulus
    initial begin
        byte_req_t rows [$];
        imu_sample_t z;
        errors = 0;
        pending_fixed = 0;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        burst_byte = 8'h00;
        frame_start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CfgGyroRange;
        cfg_data = 48'h0;
        gyro_sel = 2'd0;
        accel_sel = 2'd0;
        mag_sens = 24'h808080;
        accel_bias = 48'h0;
        iron_offset = 48'h0;
        iron_gain = 48'h400040004000;
        byte_pos = 0;
        foreach (burst_buf[i]) burst_buf[i] = 8'h00;
        foreach (held_motion[i]) held_motion[i] = 32'sd0;
        foreach (held_field[i]) held_field[i] = 32'sd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: status and ST1 clear after reset, all zeros held (typed in)
        for (int i = 0; i < 3; i++)
        begin
            z.acc[i] = 32'sd0;
            z.rate[i] = 32'sd0;
            z.fld[i] = 32'sd0;
        end
        z.motion = 1'b0;
        z.field = 1'b0;
        fixed_sample = z;
        pending_fixed = 1;
        for (int i = 0; i < BurstLen; i++)
            rows.push_back('{data: 8'hfe, start: (i == 0)});
        // resync in the middle of a partial burst, then extremes, ST1 clear
        rows.push_back('{data: 8'h00, start: 1'b1});
        rows.push_back('{data: 8'h11, start: 1'b0});
        rows.push_back('{data: 8'h01, start: 1'b1});
        for (int i = 1; i < BurstLen; i++)
            rows.push_back('{data: (i % 2) ? 8'h80 : 8'h00, start: 1'b0});
        // burst end wraps without frame_start: max positive accel and rate, field update
        for (int i = 0; i < BurstLen; i++)
            rows.push_back('{data: (i == 0 || i == 16) ? 8'h01 :
                (i == 23) ? 8'h00 : ((i % 2) ? 8'h7f : 8'hff), start: 1'b0});
        foreach (rows[i])
            send_byte(rows[i].data, rows[i].start);
        drain_all();

        // Random phases over several register settings, extremes first
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
            begin
                write_cfg(CfgGyroRange, 48'd3);
                write_cfg(CfgAccelRange, 48'd3);
                write_cfg(CfgMagAdjust, 48'hffffff);
                write_cfg(CfgAccelOffset, 48'h800080008000);
                write_cfg(CfgHardIron, 48'h7fff7fff7fff);
                write_cfg(CfgSoftIron, 48'hffffffffffff);
            end
            else if (ph == 1)
            begin
                write_cfg(CfgGyroRange, 48'd0);
                write_cfg(CfgAccelRange, 48'd0);
                write_cfg(CfgMagAdjust, 48'h0);
                write_cfg(CfgAccelOffset, 48'h7fff7fff7fff);
                write_cfg(CfgHardIron, 48'h800080008000);
                write_cfg(CfgSoftIron, 48'h0);
            end
            else
                random_cfg();
            // long receiver hold so the block backs up
            if (ph == 2)
                long_hold_req = 1'b1;
            for (int k = 0; k < 9; k++)
                random_burst();
            drain_all();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
